// ===== src/lc3_pkg.sv =====
// Package for the LC-3 instruction executor: command codes, opcodes, constants.
// No dependencies.
package lc3_pkg;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_STEP  = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic [3:0] OP_BR   = 4'h0;
   localparam logic [3:0] OP_ADD  = 4'h1;
   localparam logic [3:0] OP_LD   = 4'h2;
   localparam logic [3:0] OP_ST   = 4'h3;
   localparam logic [3:0] OP_JSR  = 4'h4;
   localparam logic [3:0] OP_AND  = 4'h5;
   localparam logic [3:0] OP_LDR  = 4'h6;
   localparam logic [3:0] OP_STR  = 4'h7;
   localparam logic [3:0] OP_RTI  = 4'h8;
   localparam logic [3:0] OP_NOT  = 4'h9;
   localparam logic [3:0] OP_LDI  = 4'hA;
   localparam logic [3:0] OP_STI  = 4'hB;
   localparam logic [3:0] OP_JMP  = 4'hC;
   localparam logic [3:0] OP_LEA  = 4'hE;
   localparam logic [3:0] OP_TRAP = 4'hF;

   localparam logic [15:0] MCR_ADDR = 16'hFFFE;

   // memory address source
   typedef enum logic [2:0] {
      MA_HOST, MA_PC, MA_OFF9, MA_OFF6, MA_R6, MA_TRAP, MA_MDR, MA_MCR
   } maddr_sel_type;

   // controller to datapath
   typedef struct packed {
      maddr_sel_type maddr_sel;
      logic          mem_we;      // write memory
      logic          mem_host_wd; // write data from host, else register
      logic          load_ir;
      logic          load_mdr;
      logic          exec;        // retire instruction (regs, pc, flags)
      logic          load_run;    // capture MCR bit 15
      logic          load_rsp;    // capture response word
      logic          rsp_read;    // response read_data from memory
      logic          rsp_exec;
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic [3:0] opcode;
   } stat_type;

endpackage

// ===== src/lc3_if.sv =====
// Valid/ready channel interface carrying one payload word.
// Depends on nothing; payload type is a parameter.
interface lc3_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== src/lc3_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module lc3_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

// ===== src/lc3_ctrl.sv =====
// Controller state machine for the LC-3 executor.
// Depends on lc3_pkg.
module lc3_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [1:0]        req_command,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic              run_bit,
   input  lc3_pkg::stat_type stat,
   output lc3_pkg::ctl_type  ctl,
   output logic              cmd_load
);
   typedef enum logic [3:0] {
      S_IDLE, S_HWR, S_HRD, S_CHK, S_CHKW, S_FETCH, S_FWAIT, S_DEC,
      S_M1, S_M1W, S_M2, S_M2W, S_EXEC, S_STAT, S_STATW, S_OUT
   } state_type;

   state_type  state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] cmd_ff, cmd_in;

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign cmd_load  = req_valid && req_ready;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ctl          = '0;
      ctl.maddr_sel = lc3_pkg::MA_MCR;
      case (state_ff)
         S_IDLE: begin
            if (cmd_load) begin
               cmd_in = req_command;
               case (req_command)
                  lc3_pkg::CMD_WRITE: state_in = S_HWR;
                  lc3_pkg::CMD_READ:  state_in = S_HRD;
                  lc3_pkg::CMD_STEP:  state_in = S_CHK;
                  default:            state_in = S_STAT;
               endcase
            end
         end
         S_HWR: begin
            ctl.maddr_sel   = lc3_pkg::MA_HOST;
            ctl.mem_we      = 1'b1;
            ctl.mem_host_wd = 1'b1;
            state_in        = S_STAT;
         end
         S_HRD: begin
            ctl.maddr_sel = lc3_pkg::MA_HOST;
            state_in      = S_M1W;
         end
         S_CHK:  state_in = S_CHKW;
         // record whether the step runs; a halted step drops to status
         S_CHKW: begin
            ctl.load_rsp = 1'b1;
            ctl.rsp_exec = run_bit;
            state_in     = run_bit ? S_FETCH : S_STAT;
         end
         S_FETCH: begin
            ctl.maddr_sel = lc3_pkg::MA_PC;
            state_in      = S_FWAIT;
         end
         S_FWAIT: begin
            ctl.load_ir = 1'b1;
            state_in    = S_DEC;
         end
         S_DEC: begin
            state_in = S_EXEC;
            case (stat.opcode) inside
               lc3_pkg::OP_LD, lc3_pkg::OP_LDI, lc3_pkg::OP_STI: begin
                  ctl.maddr_sel = lc3_pkg::MA_OFF9;
                  state_in      = S_M1W;
               end
               lc3_pkg::OP_LDR: begin
                  ctl.maddr_sel = lc3_pkg::MA_OFF6;
                  state_in      = S_M1W;
               end
               lc3_pkg::OP_RTI: begin
                  ctl.maddr_sel = lc3_pkg::MA_R6;
                  state_in      = S_M1W;
               end
               lc3_pkg::OP_TRAP: begin
                  ctl.maddr_sel = lc3_pkg::MA_TRAP;
                  state_in      = S_M1W;
               end
               lc3_pkg::OP_ST: begin
                  ctl.maddr_sel = lc3_pkg::MA_OFF9;
                  ctl.mem_we    = 1'b1;
               end
               lc3_pkg::OP_STR: begin
                  ctl.maddr_sel = lc3_pkg::MA_OFF6;
                  ctl.mem_we    = 1'b1;
               end
               default: ;
            endcase
         end
         S_M1W: begin
            ctl.load_mdr = 1'b1;
            if (cmd_ff == lc3_pkg::CMD_READ) begin
               ctl.load_rsp = 1'b1;
               ctl.rsp_read = 1'b1;
               state_in     = S_STAT;
            end else if (stat.opcode == lc3_pkg::OP_LDI ||
                         stat.opcode == lc3_pkg::OP_STI) begin
               state_in = S_M2;
            end else begin
               state_in = S_EXEC;
            end
         end
         S_M2: begin
            ctl.maddr_sel = lc3_pkg::MA_MDR;
            ctl.mem_we    = (stat.opcode == lc3_pkg::OP_STI);
            state_in      = (stat.opcode == lc3_pkg::OP_STI) ? S_EXEC : S_M2W;
         end
         S_M2W: begin
            ctl.load_mdr = 1'b1;
            state_in     = S_EXEC;
         end
         S_EXEC: begin
            ctl.exec = 1'b1;
            state_in = S_STAT;
         end
         S_STAT: state_in = S_STATW;
         S_STATW: begin
            ctl.load_run = 1'b1;
            ctl.load_rsp = (cmd_ff != lc3_pkg::CMD_READ) &&
                           (cmd_ff != lc3_pkg::CMD_STEP);
            state_in     = S_OUT;
         end
         S_OUT: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // hold state and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cmd_ff       <= lc3_pkg::CMD_WRITE;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cmd_ff       <= cmd_in;
      end
   end
endmodule

// ===== src/lc3_dpath.sv =====
// Datapath for the LC-3 executor: registers, PC, flags, memory, response word.
// Depends on lc3_pkg and lc3_ram.
module lc3_dpath (
   input  logic              clock,
   input  logic              reset,
   input  logic [15:0]       start_address,
   input  logic              csr_write,
   input  logic              cmd_load,
   input  logic [15:0]       req_address,
   input  logic [15:0]       req_write_data,
   input  lc3_pkg::ctl_type  ctl,
   output lc3_pkg::stat_type stat,
   output logic              run_bit,
   output logic [15:0]       rsp_read_data,
   output logic [15:0]       rsp_program_counter,
   output logic              rsp_flag_n,
   output logic              rsp_flag_z,
   output logic              rsp_flag_p,
   output logic              rsp_running,
   output logic              rsp_executed
);
   logic [15:0] regs_ff [8];
   logic [15:0] pc_ff, ir_ff, mdr_ff, addr_ff, wd_ff;
   logic [2:0]  nzp_ff;
   logic        mcr_init_ff, run_ff, mcr_fresh_ff;
   logic [15:0] rd_ff, rpc_ff;
   logic [2:0]  rnzp_ff;
   logic        rexec_ff;

   logic [15:0] maddr, mwdata, mrdata, npc, off9, off6, sr1v, opb, wbval, pc_in;
   logic [15:0] mdata;
   logic [2:0]  dr, sr1;
   logic        wb_en, r7_en, r6_en;

   assign dr   = ir_ff[11:9];
   assign sr1  = ir_ff[8:6];
   assign npc  = pc_ff + 16'd1;
   assign off9 = npc + {{7{ir_ff[8]}}, ir_ff[8:0]};
   assign sr1v = regs_ff[sr1];
   assign off6 = sr1v + {{10{ir_ff[5]}}, ir_ff[5:0]};
   assign opb  = ir_ff[5] ? {{11{ir_ff[4]}}, ir_ff[4:0]} : regs_ff[ir_ff[2:0]];
   assign stat.opcode = ir_ff[15:12];

   // select memory address
   always_comb begin
      case (ctl.maddr_sel)
         lc3_pkg::MA_HOST: maddr = addr_ff;
         lc3_pkg::MA_PC:   maddr = pc_ff;
         lc3_pkg::MA_OFF9: maddr = off9;
         lc3_pkg::MA_OFF6: maddr = off6;
         lc3_pkg::MA_R6:   maddr = regs_ff[6];
         lc3_pkg::MA_TRAP: maddr = {8'd0, ir_ff[7:0]};
         lc3_pkg::MA_MDR:  maddr = mdr_ff;
         default:          maddr = lc3_pkg::MCR_ADDR;
      endcase
   end
   assign mwdata = ctl.mem_host_wd ? wd_ff : regs_ff[dr];

   lc3_ram #(.WIDTH(16), .DEPTH(65536)) u_mem (
      .clock (clock),
      .we    (ctl.mem_we),
      .addr  (maddr),
      .wdata (mwdata),
      .rdata (mrdata)
   );

   // MCR reads as 0x8000 until first written
   assign mdata = mcr_fresh_ff ? 16'h8000 : mrdata;

   // writeback and next pc
   always_comb begin
      wbval = 16'd0;
      wb_en = 1'b0;
      r7_en = 1'b0;
      r6_en = 1'b0;
      pc_in = npc;
      case (stat.opcode)
         lc3_pkg::OP_BR:  if ((dr & nzp_ff) != 3'd0) pc_in = off9;
         lc3_pkg::OP_ADD: begin wbval = sr1v + opb; wb_en = 1'b1; end
         lc3_pkg::OP_AND: begin wbval = sr1v & opb; wb_en = 1'b1; end
         lc3_pkg::OP_NOT: begin wbval = ~sr1v; wb_en = 1'b1; end
         lc3_pkg::OP_LD, lc3_pkg::OP_LDR, lc3_pkg::OP_LDI: begin
            wbval = mdr_ff;
            wb_en = 1'b1;
         end
         lc3_pkg::OP_LEA: begin wbval = off9; wb_en = 1'b1; end
         lc3_pkg::OP_JSR: begin
            r7_en = 1'b1;
            pc_in = ir_ff[11] ? npc + {{5{ir_ff[10]}}, ir_ff[10:0]} : sr1v;
         end
         lc3_pkg::OP_JMP:  pc_in = sr1v;
         lc3_pkg::OP_TRAP: begin r7_en = 1'b1; pc_in = mdr_ff; end
         lc3_pkg::OP_RTI:  begin r6_en = 1'b1; pc_in = mdr_ff; end
         default: ;
      endcase
   end

   // hold architectural state
   always_ff @(posedge clock) begin
      if (cmd_load) begin
         addr_ff <= req_address;
         wd_ff   <= req_write_data;
      end
      if (ctl.load_ir) ir_ff <= mdata;
      if (ctl.load_mdr) mdr_ff <= mdata;
      if (ctl.exec) begin
         if (wb_en) regs_ff[dr] <= wbval;
         if (r7_en) regs_ff[7] <= npc;
         if (r6_en) regs_ff[6] <= regs_ff[6] + 16'd1;
      end
      if (ctl.load_rsp) begin
         rd_ff    <= ctl.rsp_read ? mdata : 16'd0;
         rexec_ff <= ctl.rsp_exec;
      end
   end

   // control state: pc, flags, run bit
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= 16'h3000;
         nzp_ff       <= 3'd0;
         mcr_init_ff  <= 1'b0;
         mcr_fresh_ff <= 1'b0;
         run_ff       <= 1'b1;
         rpc_ff       <= 16'h3000;
         rnzp_ff      <= 3'd0;
      end else begin
         if (csr_write) begin
            pc_ff <= start_address;
         end else if (ctl.exec) begin
            pc_ff <= pc_in;
         end
         if (ctl.exec && wb_en) begin
            nzp_ff <= (wbval == 16'd0) ? 3'b010 : (wbval[15] ? 3'b100 : 3'b001);
         end
         // mark a read of the MCR before its first write
         mcr_fresh_ff <= !mcr_init_ff && (maddr == lc3_pkg::MCR_ADDR);
         if (ctl.mem_we && maddr == lc3_pkg::MCR_ADDR) mcr_init_ff <= 1'b1;
         if (ctl.load_run) begin
            run_ff  <= mdata[15];
            rpc_ff  <= pc_ff;
            rnzp_ff <= nzp_ff;
         end
      end
   end

   assign run_bit             = mdata[15];
   assign rsp_read_data       = rd_ff;
   assign rsp_program_counter = rpc_ff;
   assign rsp_flag_n          = rnzp_ff[2];
   assign rsp_flag_z          = rnzp_ff[1];
   assign rsp_flag_p          = rnzp_ff[0];
   assign rsp_running         = run_ff;
   assign rsp_executed        = rexec_ff;
endmodule

// ===== src/lc3_instruction_executor.sv =====
// LC-3 core: host memory write/read commands and single-instruction steps.
// Steps share the single memory port: LD/LDR/RTI/TRAP add one data read, LDI two dependent
// reads, and STI a read of the pointer followed by a dependent write.
// One command at a time; the next word is taken the cycle after the response is taken.
// Synchronous reset: PC to 0x3000, flags clear, MCR reads 0x8000 until written.
module lc3_instruction_executor (
   input  logic  clock,
   input  logic  reset,
   input  logic        csr_write,
   input  logic [15:0] csr_data,
   lc3_if.sink   req,
   lc3_if.source rsp
);
   lc3_pkg::ctl_type  ctl;
   lc3_pkg::stat_type stat;
   logic run_bit, cmd_load;

   lc3_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req.valid),
      .req_command (req.data.command),
      .req_ready   (req.ready),
      .rsp_valid   (rsp.valid),
      .rsp_ready   (rsp.ready),
      .run_bit     (run_bit),
      .stat        (stat),
      .ctl         (ctl),
      .cmd_load    (cmd_load)
   );

   lc3_dpath u_dpath (
      .clock               (clock),
      .reset               (reset),
      .start_address       (csr_data),
      .csr_write           (csr_write),
      .cmd_load            (cmd_load),
      .req_address         (req.data.address),
      .req_write_data      (req.data.write_data),
      .ctl                 (ctl),
      .stat                (stat),
      .run_bit             (run_bit),
      .rsp_read_data       (rsp.data.read_data),
      .rsp_program_counter (rsp.data.program_counter),
      .rsp_flag_n          (rsp.data.flag_n),
      .rsp_flag_z          (rsp.data.flag_z),
      .rsp_flag_p          (rsp.data.flag_p),
      .rsp_running         (rsp.data.running),
      .rsp_executed        (rsp.data.executed)
   );
endmodule

// ===== dv/tb_lc3_instruction_executor.sv =====
// Testbench for lc3_instruction_executor: a self-checking run of memory writes,
// reads and single-instruction steps against a built-in machine model.
// Depends on lc3_pkg, lc3_if and lc3_instruction_executor (src/).
`timescale 1ns / 100ps

module tb_lc3_instruction_executor;

   localparam logic [1:0] CMD_NONE = 2'd3;
   localparam logic [3:0] OP_RESV  = 4'hD;
   localparam int CYCLE_LIMIT      = 600000;
   localparam int DRAIN_CYCLES     = 24;

   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] address;
      logic [15:0] write_data;
   } req_word_type;

   typedef struct packed {
      logic [15:0] read_data;
      logic [15:0] program_counter;
      logic        flag_n;
      logic        flag_z;
      logic        flag_p;
      logic        running;
      logic        executed;
   } rsp_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write = 1'b0;
   logic [15:0] csr_data = 16'h0;

   lc3_if #(.payload_type(req_word_type)) req_ch ();
   lc3_if #(.payload_type(rsp_word_type)) rsp_ch ();

   lc3_instruction_executor u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_data  (csr_data),
      .req       (req_ch.sink),
      .rsp       (rsp_ch.source)
   );

   always #5 clock = ~clock;

   // machine state as the core should hold it
   logic [15:0] cpu_regs [8];
   logic [15:0] cpu_pc;
   logic        cpu_n, cpu_z, cpu_p;
   logic [15:0] cpu_mem [65536];
   bit          mem_valid [65536];
   logic [15:0] valid_addrs [$];

   req_word_type pending_words [$];
   rsp_word_type pending_results [$];
   rsp_word_type awaited_results [$];

   int          error_count = 0;
   int          cycle_count = 0;

   // memory store that also tracks which words hold defined data
   function automatic void mem_store(logic [15:0] a, logic [15:0] v);
      cpu_mem[a] = v;
      if (!mem_valid[a]) begin
         mem_valid[a] = 1'b1;
         valid_addrs.push_back(a);
      end
   endfunction

   function automatic void reg_store(logic [2:0] r, logic [15:0] v);
      cpu_regs[r] = v;
      cpu_n = v[15];
      cpu_z = (v == 16'h0);
      cpu_p = !v[15] && (v != 16'h0);
   endfunction

   // advance the machine by one word and return the response it yields
   function automatic rsp_word_type machine_apply(req_word_type w);
      rsp_word_type r;
      logic [15:0]  inst, npc, off9, off6, b;
      logic [2:0]   dr, sr1;
      r = '0;
      case (w.command)
         lc3_pkg::CMD_WRITE: mem_store(w.address, w.write_data);
         lc3_pkg::CMD_READ:  r.read_data = cpu_mem[w.address];
         lc3_pkg::CMD_STEP: if (cpu_mem[lc3_pkg::MCR_ADDR][15]) begin
            inst = cpu_mem[cpu_pc];
            npc  = cpu_pc + 16'd1;
            dr   = inst[11:9];
            sr1  = inst[8:6];
            off9 = npc + {{7{inst[8]}}, inst[8:0]};
            off6 = cpu_regs[sr1] + {{10{inst[5]}}, inst[5:0]};
            case (inst[15:12])
               lc3_pkg::OP_BR:
                  if ((inst[11] && cpu_n) || (inst[10] && cpu_z) ||
                      (inst[9] && cpu_p))
                     npc = off9;
               lc3_pkg::OP_ADD: begin
                  b = inst[5] ? {{11{inst[4]}}, inst[4:0]} : cpu_regs[inst[2:0]];
                  reg_store(dr, cpu_regs[sr1] + b);
               end
               lc3_pkg::OP_LD:  reg_store(dr, cpu_mem[off9]);
               lc3_pkg::OP_ST:  mem_store(off9, cpu_regs[dr]);
               lc3_pkg::OP_JSR: begin
                  b = inst[11] ? npc + {{5{inst[10]}}, inst[10:0]} : cpu_regs[sr1];
                  cpu_regs[7] = npc;
                  npc = b;
               end
               lc3_pkg::OP_AND: begin
                  b = inst[5] ? {{11{inst[4]}}, inst[4:0]} : cpu_regs[inst[2:0]];
                  reg_store(dr, cpu_regs[sr1] & b);
               end
               lc3_pkg::OP_LDR: reg_store(dr, cpu_mem[off6]);
               lc3_pkg::OP_STR: mem_store(off6, cpu_regs[dr]);
               lc3_pkg::OP_RTI: begin
                  npc = cpu_mem[cpu_regs[6]];
                  cpu_regs[6] = cpu_regs[6] + 16'd1;
               end
               lc3_pkg::OP_NOT: reg_store(dr, ~cpu_regs[sr1]);
               lc3_pkg::OP_LDI: reg_store(dr, cpu_mem[cpu_mem[off9]]);
               lc3_pkg::OP_STI: mem_store(cpu_mem[off9], cpu_regs[dr]);
               lc3_pkg::OP_JMP: npc = cpu_regs[sr1];
               lc3_pkg::OP_LEA: reg_store(dr, off9);
               lc3_pkg::OP_TRAP: begin
                  cpu_regs[7] = npc;
                  npc = cpu_mem[{8'h0, inst[7:0]}];
               end
               default: ;
            endcase
            cpu_pc = npc;
            r.executed = 1'b1;
         end
         default: ;
      endcase
      r.program_counter = cpu_pc;
      r.flag_n  = cpu_n;
      r.flag_z  = cpu_z;
      r.flag_p  = cpu_p;
      r.running = cpu_mem[lc3_pkg::MCR_ADDR][15];
      return r;
   endfunction

   task automatic put_word(logic [1:0] cmd, logic [15:0] a, logic [15:0] d);
      req_word_type w;
      w = '{command: cmd, address: a, write_data: d};
      pending_results.push_back(machine_apply(w));
      pending_words.push_back(w);
   endtask

   // give an undefined word random content before it is read
   task automatic define_word(logic [15:0] a);
      if (!mem_valid[a])
         put_word(lc3_pkg::CMD_WRITE, a, 16'($urandom));
   endtask

   // place an instruction at the PC, define what it reads, then step it
   task automatic run_inst(logic [15:0] inst);
      logic [15:0] off9;
      if (cpu_mem[lc3_pkg::MCR_ADDR][15]) begin
         put_word(lc3_pkg::CMD_WRITE, cpu_pc, inst);
         off9 = cpu_pc + 16'd1 + {{7{inst[8]}}, inst[8:0]};
         case (inst[15:12])
            lc3_pkg::OP_LD, lc3_pkg::OP_STI: define_word(off9);
            lc3_pkg::OP_LDR:
               define_word(cpu_regs[inst[8:6]] + {{10{inst[5]}}, inst[5:0]});
            lc3_pkg::OP_LDI: begin
               define_word(off9);
               define_word(cpu_mem[off9]);
            end
            lc3_pkg::OP_RTI:  define_word(cpu_regs[6]);
            lc3_pkg::OP_TRAP: define_word({8'h0, inst[7:0]});
            default: ;
         endcase
      end
      put_word(lc3_pkg::CMD_STEP, 16'($urandom), 16'($urandom));
   endtask

   task automatic read_any();
      put_word(lc3_pkg::CMD_READ,
               valid_addrs[$urandom_range(0, valid_addrs.size() - 1)],
               16'($urandom));
   endtask

   task automatic directed_words();
      // define every register first: LEA reads no register
      for (int r = 0; r < 8; r++)
         run_inst({lc3_pkg::OP_LEA, 3'(r), (r[0] ? 9'h100 : 9'h0FF)});
      run_inst({lc3_pkg::OP_ADD, 3'd1, 3'd2, 3'b000, 3'd3});
      run_inst({lc3_pkg::OP_ADD, 3'd1, 3'd1, 1'b1, 5'h10});
      run_inst({lc3_pkg::OP_AND, 3'd2, 3'd3, 1'b1, 5'h1F});
      run_inst({lc3_pkg::OP_AND, 3'd2, 3'd0, 3'b000, 3'd7});
      run_inst({lc3_pkg::OP_NOT, 3'd4, 3'd4, 6'h3F});
      run_inst({lc3_pkg::OP_LD, 3'd5, 9'h1FF});
      run_inst({lc3_pkg::OP_ST, 3'd5, 9'h0FF});
      run_inst({lc3_pkg::OP_LDR, 3'd6, 3'd0, 6'h20});
      run_inst({lc3_pkg::OP_STR, 3'd4, 3'd2, 6'h1F});
      run_inst({lc3_pkg::OP_BR, 3'b111, 9'h005});
      run_inst({lc3_pkg::OP_BR, 3'b000, 9'h1F0});
      run_inst({lc3_pkg::OP_JSR, 1'b1, 11'h400});
      run_inst({lc3_pkg::OP_JSR, 1'b0, 2'b00, 3'd7, 6'h0});
      run_inst({lc3_pkg::OP_RTI, 12'h0});
      run_inst({lc3_pkg::OP_LDI, 3'd3, 9'h010});
      run_inst({lc3_pkg::OP_STI, 3'd7, 9'h1EF});
      run_inst({lc3_pkg::OP_TRAP, 4'h0, 8'hFF});
      run_inst({lc3_pkg::OP_JMP, 3'd0, 3'd5, 6'h0});
      run_inst({OP_RESV, 12'hFFF});
      put_word(CMD_NONE, 16'hFFFF, 16'hFFFF);
      read_any();
      // halted machine ignores steps until the control word is restored
      put_word(lc3_pkg::CMD_WRITE, lc3_pkg::MCR_ADDR, 16'h7FFF);
      run_inst({lc3_pkg::OP_ADD, 3'd0, 3'd0, 1'b1, 5'h01});
      put_word(lc3_pkg::CMD_WRITE, lc3_pkg::MCR_ADDR, 16'h8000);
   endtask

   task automatic random_words(int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (!cpu_mem[lc3_pkg::MCR_ADDR][15] && pick < 40)
            put_word(lc3_pkg::CMD_WRITE, lc3_pkg::MCR_ADDR, 16'h8000 | 16'($urandom));
         else if (pick < 70)
            run_inst(16'($urandom));
         else if (pick < 82)
            put_word(lc3_pkg::CMD_WRITE, 16'($urandom), 16'($urandom));
         else if (pick < 85)
            put_word(lc3_pkg::CMD_WRITE, lc3_pkg::MCR_ADDR, 16'($urandom));
         else if (pick < 96)
            read_any();
         else
            put_word(CMD_NONE, 16'($urandom), 16'($urandom));
      end
   endtask

   task automatic wait_idle();
      while (pending_words.size() != 0 || req_ch.valid || awaited_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_start(logic [15:0] v);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      csr_write <= 1'b0;
      cpu_pc = v;
   endtask

   // stimulus phases: reset start address, then low, high and random starts
   initial begin
      for (int a = 0; a < 65536; a++) begin
         cpu_mem[a]   = 16'h0;
         mem_valid[a] = 1'b0;
      end
      for (int r = 0; r < 8; r++)
         cpu_regs[r] = 16'h0;
      cpu_pc = 16'h3000;
      {cpu_n, cpu_z, cpu_p} = 3'b000;
      mem_store(lc3_pkg::MCR_ADDR, 16'h8000);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      directed_words();
      random_words(90);
      wait_idle();
      write_start(16'h0000);
      random_words(90);
      wait_idle();
      write_start(16'hFFFF);
      random_words(90);
      wait_idle();
      write_start(16'($urandom));
      random_words(90);
      wait_idle();

      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // drive request words in bursts separated by random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.data  <= '0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_ch.valid <= 1'b0;
         end else if (pending_words.size() > 0) begin
            req_ch.data  <= pending_words.pop_front();
            req_ch.valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 30);
               gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // stall the response side on a random 16-bit ready pattern that always holds a set bit
   logic [15:0] stall_pattern = 16'hFFFF;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count % 256 == 255)
         stall_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF :
                          (16'($urandom) | (16'h1 << $urandom_range(0, 15)));
      rsp_ch.ready <= reset ? 1'b0 : stall_pattern[cycle_count % 16];
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // hold an expectation per accepted word; check each response word
   always @(posedge clock) begin
      rsp_word_type e, a;
      if (!reset && req_ch.valid && req_ch.ready)
         awaited_results.push_back(pending_results.pop_front());
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         a = rsp_ch.data;
         if (awaited_results.size() == 0) begin
            $display("%0t: response with none expected, actual %h", $time, a);
            error_count++;
         end else begin
            e = awaited_results.pop_front();
            if (a.read_data !== e.read_data) begin
               $display("%0t: read_data expected %h actual %h", $time, e.read_data,
                        a.read_data);
               error_count++;
            end
            if (a.program_counter !== e.program_counter) begin
               $display("%0t: program_counter expected %h actual %h", $time,
                        e.program_counter, a.program_counter);
               error_count++;
            end
            if ({a.flag_n, a.flag_z, a.flag_p} !== {e.flag_n, e.flag_z, e.flag_p}) begin
               $display("%0t: flags nzp expected %b actual %b", $time,
                        {e.flag_n, e.flag_z, e.flag_p}, {a.flag_n, a.flag_z, a.flag_p});
               error_count++;
            end
            if (a.running !== e.running) begin
               $display("%0t: running expected %b actual %b", $time, e.running,
                        a.running);
               error_count++;
            end
            if (a.executed !== e.executed) begin
               $display("%0t: executed expected %b actual %b", $time, e.executed,
                        a.executed);
               error_count++;
            end
         end
      end
   end

endmodule
